// File: design/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MaxAnims   = 16;
  localparam int MaxFrames  = 32;
  localparam int CellBits   = 10;
  localparam int AnimBits   = 4;
  localparam int SlotBits   = 5;
  localparam int CountBits  = 6;
  localparam int CtrBits    = 17;
  localparam int DivSteps   = CellBits;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_PLAY   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  localparam logic [1:0] CFG_CELLS  = 2'd0;
  localparam logic [1:0] CFG_STEP_U = 2'd1;
  localparam logic [1:0] CFG_STEP_V = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the input item and select the animation
    logic do_load;    // write the frame and the per-animation fields
    logic rd_frame;   // read the frame at the active position
    logic do_play;    // play update using the frame just read
    logic tick_add;   // add elapsed to the counter
    logic tick_step;  // one subtract-and-advance step
    logic tick_done;  // write the counter back
    logic div_start;  // start the cell division
    logic div_step;   // one restoring division step
    logic mul;        // form texture coordinates
    logic out_load;   // load the output register
  } sfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       has_frames;
    logic       tick_more;
    logic       div_last;
  } sfs_stat_t;

endpackage

// File: design/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Animation table that plays sprite frames and reports cell and texture data.
// ----------------------------------------------------------------------------
// The input stream carries one command per item: load a frame, play an
// animation, or add elapsed time. Every item yields exactly one result item
// with the active animation, its frame position, the cell column and row and
// the texture coordinates. Configuration (cells per row, texture steps) is
// written through cfg_we, cfg_index and cfg_data by the user only while the
// block is idle; the block itself does not enforce this. A load or report
// item passes through a frame store read, a ten-step restoring division of
// the cell index, a multiply and the result stage, and the next item is
// accepted only after its result is loaded. A play item adds the play update
// first. A tick on an animation with frames first adds the elapsed time, then
// reads the frame duration afresh for every frame it advances.
// Reset clears the per-animation state and selects animation zero; the frame
// stores hold garbage until loaded. When the receiver stalls, the result
// waits in the output register and the block accepts a new item, but that
// item holds before its result stage until the old result is taken.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0] anim_id[5:2] frame_slot[10:6] cell_index[20:11]
  // frame_time[36:21] loop_flag[37] elapsed[53:38]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // active_anim[3:0] frame_pos[8:4] cell_col[18:9] cell_row[28:19]
  // tex_u[44:29] tex_v[60:45] status[61]
  output logic [63:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sfs_cmd_t    cmd;
  sfs_stat_t   stat;
  logic [63:0] dp_out;

  sfs_control u_ctrl (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd, .stat
  );

  sfs_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_data ({8'd0, s_tdata}),
    .cfg_we, .cfg_index, .cfg_data,
    .out_data(dp_out)
  );

  assign m_tdata = dp_out;

endmodule

// File: design/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// Frame stores, per-animation state, divider and texture multiplier.
// ----------------------------------------------------------------------------
module sfs_datapath
  import sfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  sfs_cmd_t             cmd,
  output sfs_stat_t            stat,
  input  logic [63:0]          in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic [63:0]          out_data
);

  logic [10:0] cells_per_row;
  logic [15:0] step_u;
  logic [15:0] step_v;

  logic [CellBits-1:0] cell_mem [MaxAnims*MaxFrames];
  logic [15:0]         time_mem [MaxAnims*MaxFrames];

  logic [CountBits-1:0] frame_count   [MaxAnims];
  logic                 repeat_flag   [MaxAnims];
  logic [SlotBits-1:0]  play_position [MaxAnims];
  logic [CtrBits-1:0]   time_counter  [MaxAnims];
  logic [AnimBits-1:0]  current_anim;

  // Captured item.
  logic [1:0]          c_cmd;
  logic [AnimBits-1:0] c_id;
  logic [SlotBits-1:0] c_slot;
  logic [CellBits-1:0] c_cell;
  logic [15:0]         c_ftime;
  logic                c_loop;
  logic [15:0]         c_el;
  logic                c_change;

  logic [CellBits-1:0] rd_cell;
  logic [15:0]         rd_time;
  logic [CtrBits-1:0]  ctr;
  logic [SlotBits-1:0] pos;

  logic [AnimBits-1:0] act;
  logic [16:0]         dur;
  logic [SlotBits:0]   pos_inc;
  logic [SlotBits-1:0] pos_wrap;
  logic [SlotBits-1:0] pos_hold;
  logic [CtrBits:0]    ctr_sum;

  // Divider.
  logic [CellBits-1:0] quo;
  logic [10:0]         rem;
  logic [11:0]         rem_try;
  logic [10:0]         divisor;
  logic [3:0]          div_cnt;
  logic [25:0]         prod_u;
  logic [25:0]         prod_v;

  logic [63:0]         out_next;

  assign act      = current_anim;
  assign dur      = (rd_time == 16'd0) ? 17'd1 : {1'b0, rd_time};
  assign pos_inc  = {1'b0, pos} + 1'b1;
  assign pos_wrap = (pos_inc >= {1'b0, frame_count[act]}) ? '0 : pos_inc[SlotBits-1:0];
  assign pos_hold = (pos_inc >= {1'b0, frame_count[act]}) ?
                    SlotBits'(frame_count[act] - 1'b1) : pos_inc[SlotBits-1:0];
  assign ctr_sum  = {1'b0, time_counter[act]} + {2'b00, c_el};
  assign divisor  = (cells_per_row == 11'd0) ? 11'd1 : cells_per_row;
  assign rem_try  = {rem, quo[CellBits-1]} - {1'b0, divisor};

  assign stat.cmd        = c_cmd;
  assign stat.has_frames = frame_count[act] != '0;
  assign stat.tick_more  = ctr >= dur;
  assign stat.div_last   = div_cnt == 4'(DivSteps - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_row <= 11'd1;
      step_u        <= 16'hFFFF;
      step_v        <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELLS:  cells_per_row <= cfg_data[10:0];
        CFG_STEP_U: step_u        <= cfg_data;
        CFG_STEP_V: step_v        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame stores: one write, one registered read at the active position.
  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      cell_mem[{c_id, c_slot}] <= c_cell;
      time_mem[{c_id, c_slot}] <= c_ftime;
    end
    if (cmd.rd_frame) begin
      rd_cell <= cell_mem[{act, play_position[act]}];
      rd_time <= time_mem[{act, play_position[act]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxAnims; i++) begin
        frame_count[i]   <= '0;
        repeat_flag[i]   <= 1'b0;
        play_position[i] <= '0;
        time_counter[i]  <= '0;
      end
      current_anim <= '0;
      c_change     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        c_cmd    <= in_data[1:0];
        c_id     <= in_data[5:2];
        c_slot   <= in_data[10:6];
        c_cell   <= in_data[20:11];
        c_ftime  <= in_data[36:21];
        c_loop   <= in_data[37];
        c_el     <= in_data[53:38];
        c_change <= in_data[1:0] == CMD_PLAY && in_data[5:2] != current_anim;
        if (in_data[1:0] == CMD_PLAY) current_anim <= in_data[5:2];
      end
      if (cmd.do_load) begin
        frame_count[c_id] <= CountBits'(c_slot) + 1'b1;
        repeat_flag[c_id] <= c_loop;
        if (c_slot == '0) begin
          play_position[c_id] <= '0;
          time_counter[c_id]  <= '0;
        end
      end
      if (cmd.rd_frame && !cmd.tick_step) pos <= play_position[act];
      if (cmd.do_play && c_change) begin
        if ({time_counter[act], 1'b0} >= {1'b0, dur}) play_position[act] <= pos_wrap;
        time_counter[act] <= '0;
      end
      if (cmd.tick_add) ctr <= ctr_sum[CtrBits] ? '1 : ctr_sum[CtrBits-1:0];
      if (cmd.tick_step) begin
        ctr <= ctr - dur;
        pos <= repeat_flag[act] ? pos_wrap : pos_hold;
        play_position[act] <= repeat_flag[act] ? pos_wrap : pos_hold;
      end
      if (cmd.tick_done) time_counter[act] <= ctr;
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo     <= rd_cell;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!rem_try[11]) begin
        rem <= rem_try[10:0];
        quo <= {quo[CellBits-2:0], 1'b1};
      end else begin
        rem <= {rem[9:0], quo[CellBits-1]};
        quo <= {quo[CellBits-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.mul) begin
      prod_u <= rem[9:0] * step_u;
      prod_v <= quo * step_v;
    end
  end

  always_comb begin
    out_next      = '0;
    out_next[3:0] = act;
    if (frame_count[act] == '0) begin
      out_next[61] = 1'b1;
    end else begin
      out_next[8:4]   = play_position[act];
      out_next[18:9]  = rem[9:0];
      out_next[28:19] = quo;
      out_next[44:29] = (prod_u[25:16] != '0) ? 16'hFFFF : prod_u[15:0];
      out_next[60:45] = (prod_v[25:16] != '0) ? 16'hFFFF : prod_v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= out_next;
  end

endmodule

// File: design/sfs_control.sv
// ----------------------------------------------------------------------------
// sfs_control
// Sequencer that steps one item through load, play, tick and report phases.
// ----------------------------------------------------------------------------
module sfs_control
  import sfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sfs_cmd_t  cmd,
  input  sfs_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_PLAY, S_TADD, S_TRD, S_TCHK, S_RD, S_RDW,
    S_DIV, S_MUL, S_OUT, S_HOLD
  } state_t;

  state_t state;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.capture = in_valid && state == S_IDLE;
    unique case (state)
      S_EXEC: begin
        cmd.do_load  = stat.cmd == CMD_LOAD;
        cmd.rd_frame = 1'b1;
      end
      S_PLAY: cmd.do_play  = stat.has_frames;
      S_TADD: cmd.tick_add = 1'b1;
      S_TRD:  cmd.rd_frame = 1'b1;
      S_TCHK: begin
        cmd.tick_step = stat.tick_more;
        cmd.tick_done = !stat.tick_more;
        cmd.rd_frame  = stat.tick_more;
      end
      S_RD:   cmd.rd_frame  = 1'b1;
      S_RDW:  cmd.div_start = 1'b1;
      S_DIV:  cmd.div_step  = 1'b1;
      S_MUL:  cmd.mul       = 1'b1;
      S_OUT:  cmd.out_load  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          priority if (stat.cmd == CMD_PLAY) state <= S_PLAY;
          else if (stat.cmd == CMD_TICK && stat.has_frames) state <= S_TADD;
          else state <= S_RD;
        end
        S_PLAY: state <= S_RD;
        S_TADD: state <= S_TRD;
        S_TRD:  state <= S_TCHK;
        S_TCHK: state <= stat.tick_more ? S_TRD : S_RD;
        S_RD:   state <= S_RDW;
        S_RDW:  state <= S_DIV;
        S_DIV:  if (stat.div_last) state <= S_MUL;
        S_MUL:  state <= S_HOLD;
        S_HOLD: if (!out_valid || out_ready) state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready) else $error("result overwritten");
  a_step_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_step |-> stat.cmd == CMD_TICK) else $error("tick step outside tick");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the sprite frame sequencer.
// ----------------------------------------------------------------------------
// A short table of directed items comes first. It covers the reset state,
// empty animations, zero and maximum frame durations, looping and holding
// playback, a play that advances the frame, and a load that shrinks an
// animation below its play position. Random items follow, over several
// register settings and idling patterns.
//
// Every item is applied to a model of the animation table kept here, which
// predicts its result unless a directed row gives one. Each result is
// compared field by field with the oldest expected result. Frames are only
// loaded in order from slot zero, so that no unwritten frame can be read.
// ----------------------------------------------------------------------------
module tb
  import sfs_pkg::*;
;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int          RandPerPhase = 305;

  typedef struct {
    bit [1:0]  cmd;
    bit [3:0]  anim;
    bit [4:0]  slot;
    bit [9:0]  cell_idx;
    bit [15:0] ftime;
    bit        loop_en;
    bit [15:0] elapsed;
  } seq_item_t;

  typedef struct {
    bit [3:0]  anim;
    bit [4:0]  pos;
    bit [9:0]  col;
    bit [9:0]  row;
    bit [15:0] tex_u;
    bit [15:0] tex_v;
    bit        status;
  } sprite_res_t;

  typedef struct {
    seq_item_t   it;
    bit          typed;
    sprite_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CELLS;
  logic [15:0] cfg_data = '0;

  sprite_frame_sequencer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model of the animation table.
  bit [9:0]  cell_mem [MaxAnims][MaxFrames];
  bit [15:0] dur_mem  [MaxAnims][MaxFrames];
  bit [5:0]  frames   [MaxAnims];
  bit        repeats  [MaxAnims];
  bit [4:0]  play_pos [MaxAnims];
  bit [16:0] elapsed_ctr [MaxAnims];
  bit [3:0]  sel_anim;
  bit [10:0] cells_row;
  bit [15:0] u_step;
  bit [15:0] v_step;
  // Number of slots written in order from slot zero, per animation.
  int        loaded_len [MaxAnims];

  sprite_res_t expected_sprites[$];
  dir_row_t    dir_rows[$];
  int          errors;
  int unsigned cycles;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          hold_left;

  // Duration of the frame at the play position; zero counts as one.
  function automatic bit [16:0] frame_dur(bit [3:0] a);
    bit [15:0] d;
    d = dur_mem[a][play_pos[a]];
    return (d == 0) ? 17'd1 : {1'b0, d};
  endfunction

  function automatic void step_frame(bit [3:0] a, bit wrap);
    int nxt;
    nxt = play_pos[a] + 1;
    if (nxt >= frames[a]) nxt = wrap ? 0 : frames[a] - 1;
    play_pos[a] = nxt[4:0];
  endfunction

  // Applies one item to the table and returns the sprite it reports.
  function automatic sprite_res_t play_item(seq_item_t it);
    sprite_res_t r;
    bit [17:0]   acc;
    bit [10:0]   cpr;
    bit [31:0]   prod;
    bit [9:0]    cv;
    case (it.cmd)
      CMD_LOAD: begin
        cell_mem[it.anim][it.slot] = it.cell_idx;
        dur_mem[it.anim][it.slot] = it.ftime;
        frames[it.anim] = it.slot + 6'd1;
        repeats[it.anim] = it.loop_en;
        if (it.slot == 0) begin
          play_pos[it.anim] = 0;
          elapsed_ctr[it.anim] = 0;
        end
      end
      CMD_PLAY: begin
        if (it.anim != sel_anim && frames[it.anim] != 0) begin
          if ({elapsed_ctr[it.anim], 1'b0} >= frame_dur(it.anim)) step_frame(it.anim, 1'b1);
          elapsed_ctr[it.anim] = 0;
        end
        sel_anim = it.anim;
      end
      CMD_TICK: begin
        if (frames[sel_anim] != 0) begin
          acc = elapsed_ctr[sel_anim] + it.elapsed;
          if (acc > 18'd131071) acc = 18'd131071;
          while (acc >= frame_dur(sel_anim)) begin
            acc = acc - frame_dur(sel_anim);
            step_frame(sel_anim, repeats[sel_anim]);
          end
          elapsed_ctr[sel_anim] = acc[16:0];
        end
      end
      default: ;
    endcase
    r = '{default: 0};
    r.anim = sel_anim;
    if (frames[sel_anim] == 0) begin
      r.status = 1'b1;
    end else begin
      cpr = (cells_row == 0) ? 11'd1 : cells_row;
      cv = cell_mem[sel_anim][play_pos[sel_anim]];
      r.pos = play_pos[sel_anim];
      r.col = 10'(cv % cpr);
      r.row = 10'(cv / cpr);
      prod = r.col * u_step;
      r.tex_u = (prod > 65535) ? 16'hFFFF : prod[15:0];
      prod = r.row * v_step;
      r.tex_v = (prod > 65535) ? 16'hFFFF : prod[15:0];
    end
    return r;
  endfunction

  function automatic seq_item_t mk(bit [1:0] c, bit [3:0] a, bit [4:0] s, bit [9:0] ci,
                                   bit [15:0] ft, bit lp, bit [15:0] el);
    seq_item_t it;
    it = '{c, a, s, ci, ft, lp, el};
    return it;
  endfunction

  function automatic sprite_res_t res(bit [3:0] a, bit [4:0] p, bit [9:0] c, bit [9:0] r,
                                      bit [15:0] u, bit [15:0] v, bit st);
    sprite_res_t x;
    x = '{a, p, c, r, u, v, st};
    return x;
  endfunction

  function automatic void add_row(seq_item_t it, bit typed, sprite_res_t r);
    dir_row_t d;
    d.it = it;
    d.typed = typed;
    d.res = r;
    dir_rows.push_back(d);
  endfunction

  // Random item. Loads extend or rewrite the written prefix of a slot table.
  // Short frame durations are kept apart from long elapsed times so that a
  // single tick does not spin through tens of thousands of frame steps.
  function automatic seq_item_t rand_item();
    seq_item_t it;
    int        pick;
    int        top;
    int        a;
    bit        has_short;
    it.cmd = 2'($urandom_range(3));
    it.anim = 4'($urandom_range(15));
    it.slot = 5'($urandom_range(31));
    it.cell_idx = 10'($urandom_range(1023));
    it.ftime = 16'($urandom_range(65535));
    it.loop_en = 1'($urandom_range(1));
    it.elapsed = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 38) begin
      it.cmd = CMD_LOAD;
      top = (loaded_len[it.anim] > 31) ? 31 : loaded_len[it.anim];
      it.slot = 5'(($urandom_range(99) < 50) ? top : $urandom_range(top));
      pick = $urandom_range(99);
      if (pick < 20) it.ftime = 16'($urandom_range(15));
      else if (pick < 85) it.ftime = 16'($urandom_range(65535, 64));
    end else if (pick < 58) begin
      it.cmd = CMD_PLAY;
    end else if (pick < 92) begin
      it.cmd = CMD_TICK;
      a = sel_anim;
      has_short = 1'b0;
      for (int s = 0; s < loaded_len[a]; s++) if (dur_mem[a][s] < 256) has_short = 1'b1;
      if (has_short) it.elapsed = 16'($urandom_range(600));
      else if ($urandom_range(99) < 70) it.elapsed = 16'($urandom_range(3000));
    end else begin
      it.cmd = CMD_REPORT;
    end
    return it;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Sender side: the item is presented at a clock edge and held until taken.
  task automatic send_item(seq_item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, it.elapsed, it.loop_en, it.ftime, it.cell_idx, it.slot, it.anim,
                it.cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_item(seq_item_t it, bit typed, sprite_res_t r);
    sprite_res_t p;
    if (it.cmd == CMD_LOAD && it.slot == loaded_len[it.anim]) loaded_len[it.anim]++;
    p = play_item(it);
    expected_sprites.push_back(typed ? r : p);
    send_item(it);
  endtask

  // Register writes happen only once the block has drained and settled.
  task automatic write_regs(bit [15:0] cpr, bit [15:0] su, bit [15:0] sv);
    s_tvalid <= 1'b0;
    while (expected_sprites.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CELLS;
    cfg_data <= cpr;
    @(posedge clk);
    cfg_index <= CFG_STEP_U;
    cfg_data <= su;
    @(posedge clk);
    cfg_index <= CFG_STEP_V;
    cfg_data <= sv;
    @(posedge clk);
    cfg_we <= 1'b0;
    cells_row = cpr[10:0];
    u_step = su;
    v_step = sv;
  endtask

  // Receiver side: stalls at random, and holds off entirely while a
  // pressure stretch is counting down.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    sprite_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sprites.size() == 0) begin
        flag_mismatch("unexpected result, data low word", m_tdata[31:0], 0);
      end else begin
        want = expected_sprites.pop_front();
        if (m_tdata[3:0] != want.anim) flag_mismatch("active_anim", m_tdata[3:0], want.anim);
        if (m_tdata[8:4] != want.pos) flag_mismatch("frame_pos", m_tdata[8:4], want.pos);
        if (m_tdata[18:9] != want.col) flag_mismatch("cell_col", m_tdata[18:9], want.col);
        if (m_tdata[28:19] != want.row) flag_mismatch("cell_row", m_tdata[28:19], want.row);
        if (m_tdata[44:29] != want.tex_u) flag_mismatch("tex_u", m_tdata[44:29], want.tex_u);
        if (m_tdata[60:45] != want.tex_v) flag_mismatch("tex_v", m_tdata[60:45], want.tex_v);
        if (m_tdata[61] != want.status) flag_mismatch("status", m_tdata[61], want.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sprite_res_t none;
    bit [15:0]   cfg_cpr   [6] = '{1024, 0, 3, 2047, 7, 1024};
    bit [15:0]   cfg_u     [6] = '{65535, 0, 1000, 65535, 300, 0};
    bit [15:0]   cfg_v     [6] = '{65535, 0, 40000, 1, 300, 65535};
    int          idle_src  [4] = '{0, 84, 0, 8};
    int          idle_snk  [4] = '{0, 0, 84, 8};
    errors = 0;
    cycles = 0;
    hold_left = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    none = '{default: 0};
    // Reset state of the table and registers.
    for (int a = 0; a < MaxAnims; a++) begin
      frames[a] = 0;
      repeats[a] = 0;
      play_pos[a] = 0;
      elapsed_ctr[a] = 0;
      loaded_len[a] = 0;
    end
    sel_anim = 0;
    cells_row = 1;
    u_step = 16'hFFFF;
    v_step = 16'hFFFF;

    // Empty animations report status one and zero fields.
    add_row(mk(CMD_REPORT, 0, 0, 0, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0, 1));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1, res(0, 0, 0, 0, 0, 0, 1));
    add_row(mk(CMD_PLAY, 15, 0, 0, 0, 0, 0), 1'b1, res(15, 0, 0, 0, 0, 0, 1));
    // Largest cell with one cell per row: row 1023 saturates tex_v.
    add_row(mk(CMD_LOAD, 15, 0, 1023, 0, 1, 0), 1'b1, res(15, 0, 0, 1023, 0, 16'hFFFF, 0));
    add_row(mk(CMD_LOAD, 15, 1, 0, 16'hFFFF, 1, 0), 1'b0, none);
    // A zero duration counts as one; then a maximum duration wraps around.
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1), 1'b0, none);
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0, none);
    add_row(mk(CMD_LOAD, 0, 0, 5, 10, 0, 0), 1'b0, none);
    add_row(mk(CMD_LOAD, 0, 1, 6, 10, 0, 0), 1'b0, none);
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0), 1'b0, none);
    // Without repeat the playback holds at the last frame.
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 25), 1'b0, none);
    add_row(mk(CMD_PLAY, 15, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 3), 1'b0, none);
    // Switching back with half a duration elapsed advances the frame.
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(CMD_PLAY, 0, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(CMD_LOAD, 0, 0, 1000, 16'hFFFF, 0, 0), 1'b0, none);
    // Shrinking an animation below its play position, then advancing.
    add_row(mk(CMD_LOAD, 1, 0, 11, 1, 1, 0), 1'b0, none);
    add_row(mk(CMD_LOAD, 1, 1, 12, 1, 1, 0), 1'b0, none);
    add_row(mk(CMD_LOAD, 1, 2, 13, 1, 1, 0), 1'b0, none);
    add_row(mk(CMD_PLAY, 1, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 2), 1'b0, none);
    add_row(mk(CMD_LOAD, 1, 1, 14, 2, 1, 0), 1'b0, none);
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1), 1'b0, none);
    add_row(mk(CMD_REPORT, 15, 31, 1023, 16'hFFFF, 1, 16'hFFFF), 1'b0, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) run_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      write_regs(cfg_cpr[ph], cfg_u[ph], cfg_v[ph]);
      src_idle_pct = idle_src[ph % 4];
      snk_stall_pct = idle_snk[ph % 4];
      // The receiver holds off for a long stretch while items keep coming.
      if (ph == 4) hold_left = 600;
      for (int n = 0; n < RandPerPhase; n++) run_item(rand_item(), 1'b0, none);
    end
    s_tvalid <= 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;

    while (expected_sprites.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
